// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/edf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package edf_pkg;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] arrival;
    logic [11:0] duration;
    logic [15:0] deadline;
  } in_item_t;

  typedef struct packed {
    logic [15:0] now;
    logic [4:0]  job_index;
    logic        idle;
    logic        job_finished;
    logic        all_done;
    logic        table_full;
  } out_item_t;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] deadline;
    logic [11:0] remaining;
  } job_entry_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_load;
    logic scan_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/edf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module edf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire edf_pkg::dp_sts_t sts_i,
  output edf_pkg::dp_cmd_t     cmd_o
);
  import edf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan    = (state_q == S_SCAN);
    cmd_o.commit  = (state_q == S_COMMIT) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= sts_i.in_load ? S_COMMIT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts_i.scan_last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/edf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module edf_datapath #(
  parameter int MAX_JOBS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire edf_pkg::in_item_t in_data_i,
  input  wire edf_pkg::dp_cmd_t  cmd_i,
  output edf_pkg::dp_sts_t      sts_o,
  output edf_pkg::out_item_t    out_data_o
);
  import edf_pkg::*;

  localparam int IW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);

  job_entry_t mem_q [MAX_JOBS];

  in_item_t   item_q;
  job_entry_t rd_data_q;
  logic [IW-1:0] rd_idx_q;
  logic          rd_vld_q;
  logic [IW-1:0] scan_cnt_q;

  logic          found_q;
  job_entry_t    best_q;
  logic [IW-1:0] best_idx_q;

  logic [CW-1:0] job_count_q, job_count_d;
  logic [CW-1:0] unfin_q, unfin_d;
  logic [15:0]   time_q, time_d;

  out_item_t     out_q, res;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  job_entry_t    mem_wdata;

  logic          eligible;
  logic          better;
  logic [15:0]   time_inc;
  logic [11:0]   rem_dec;
  logic          table_is_full;
  logic [IW-1:0] idx_sel;
  logic [IW+4:0] idx_ext;

  assign sts_o.in_load   = (in_data_i.func == FUNC_LOAD);
  assign sts_o.scan_last = (scan_cnt_q == IW'(MAX_JOBS - 1));
  assign out_data_o      = out_q;

  assign eligible = rd_vld_q && (CW'(rd_idx_q) < job_count_q) &&
                    (rd_data_q.remaining != 12'd0) && (rd_data_q.arrival <= time_q);

  assign better = (rd_data_q.deadline < best_q.deadline) ||
                  ((rd_data_q.deadline == best_q.deadline) &&
                   ((rd_data_q.remaining < best_q.remaining) ||
                    ((rd_data_q.remaining == best_q.remaining) &&
                     (rd_data_q.arrival < best_q.arrival))));

  assign time_inc      = (time_q == 16'hFFFF) ? time_q : time_q + 16'd1;
  assign rem_dec       = best_q.remaining - 12'd1;
  assign table_is_full = (job_count_q == CW'(MAX_JOBS));
  assign idx_ext       = {5'b0, idx_sel};

  always_comb begin
    job_count_d = job_count_q;
    unfin_d     = unfin_q;
    time_d      = time_q;
    mem_we      = 1'b0;
    mem_waddr   = job_count_q[IW-1:0];
    mem_wdata   = '{arrival: item_q.arrival, deadline: item_q.deadline,
                    remaining: item_q.duration};
    idx_sel     = '0;
    res         = '0;
    if (item_q.func == FUNC_LOAD) begin
      if (table_is_full) begin
        res.table_full = 1'b1;
      end else begin
        mem_we      = 1'b1;
        idx_sel     = job_count_q[IW-1:0];
        job_count_d = job_count_q + CW'(1);
        if (job_count_q == '0) begin
          time_d = item_q.arrival;
        end
        if (item_q.duration != 12'd0) begin
          unfin_d = unfin_q + CW'(1);
        end
      end
      res.now = time_d;
    end else begin
      time_d  = time_inc;
      res.now = time_q;
      if (!found_q) begin
        res.idle = 1'b1;
      end else begin
        idx_sel   = best_idx_q;
        mem_we    = 1'b1;
        mem_waddr = best_idx_q;
        mem_wdata = '{arrival: best_q.arrival, deadline: best_q.deadline,
                      remaining: rem_dec};
        if (rem_dec == 12'd0) begin
          res.job_finished = 1'b1;
          res.now          = time_inc;
          if (unfin_q != '0) begin
            unfin_d = unfin_q - CW'(1);
          end
        end
      end
    end
    res.job_index = idx_ext[4:0];
    res.all_done  = (unfin_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.scan) begin
      rd_data_q <= mem_q[scan_cnt_q];
      rd_idx_q  <= scan_cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (eligible && (!found_q || better)) begin
      best_q     <= rd_data_q;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      scan_cnt_q  <= '0;
      found_q     <= 1'b0;
      job_count_q <= '0;
      unfin_q     <= '0;
      time_q      <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.capture) begin
        scan_cnt_q <= '0;
        found_q    <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          scan_cnt_q <= scan_cnt_q + IW'(1);
        end
        if (eligible) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        job_count_q <= job_count_d;
        unfin_q     <= unfin_d;
        time_q      <= time_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/edf_job_scheduler_top.sv =====
// earliest-deadline-first job scheduler over a table of MAX_JOBS jobs
// input channel in_valid_i / in_ready_o / in_data_i: a load appends a job,
// a tick runs the best arrived unfinished job for one time unit
// output channel out_valid_o / out_ready_i / out_data_o: one result per transfer
// a load's result passes the commit state into the output register
// a tick's result passes the scan, drain and commit states: the job table memory
// is read one entry per cycle and each entry is compared against the best so far,
// then the drain state finishes the last compare and the commit state writes the
// update into the output register
// in_ready_o is high only while no item is in progress, so a new item is taken
// only after the previous one has been committed
// the result sits in an output register; the next item is taken while it waits,
// and a new result is held back until the receiver takes the previous one
// reset clears job count, clock and unfinished count; table contents stay
// unwritten and only entries below the job count are ever used
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module edf_job_scheduler_top #(
  parameter int MAX_JOBS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire edf_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output edf_pkg::out_item_t     out_data_o
);
  import edf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  edf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  edf_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  `ASSERT_CLK(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  `ASSERT_CLK(a_commit_slot_free, cmd.commit |-> (!out_valid_o || out_ready_i), "result overwritten")
  `ASSERT_NEVER(a_idle_and_finished, out_valid_o && out_data_o.idle && out_data_o.job_finished, "idle tick finished a job")
  `ASSERT_NEVER(a_scan_while_ready, in_ready_o && (cmd.scan || cmd.commit), "datapath busy while ready")

endmodule

`default_nettype wire

// ===== sim/edf_job_scheduler_top_tb.sv =====
`timescale 1ns / 1ps

import edf_pkg::*;

class schedule_tracker;
  int unsigned slots;
  logic [15:0] arr_tab[];
  logic [15:0] dl_tab[];
  logic [11:0] rem_tab[];
  int unsigned n_jobs;
  int unsigned n_open;
  logic [15:0] clock_now;
  out_item_t   pending_results[$];
  int unsigned errors;

  function new(int unsigned num_slots);
    slots     = num_slots;
    arr_tab   = new[num_slots];
    dl_tab    = new[num_slots];
    rem_tab   = new[num_slots];
    n_jobs    = 0;
    n_open    = 0;
    clock_now = '0;
    errors    = 0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void note_job_item(in_item_t it);
    out_item_t res;
    int        best;
    int        j;
    bit        won;
    res = '0;
    if (it.func == FUNC_LOAD) begin
      if (n_jobs >= slots) begin
        res.table_full = 1'b1;
      end else begin
        if (n_jobs == 0) clock_now = it.arrival;
        arr_tab[n_jobs] = it.arrival;
        dl_tab[n_jobs]  = it.deadline;
        rem_tab[n_jobs] = it.duration;
        if (it.duration != 0) n_open++;
        res.job_index = 5'(n_jobs);
        n_jobs++;
      end
      res.now = clock_now;
    end else begin
      best = -1;
      for (j = 0; j < n_jobs; j++) begin
        if (rem_tab[j] != 0 && arr_tab[j] <= clock_now) begin
          // deadline, then remaining, then arrival; a full tie keeps the lower index
          if (best < 0) won = 1'b1;
          else if (dl_tab[j] != dl_tab[best]) won = dl_tab[j] < dl_tab[best];
          else if (rem_tab[j] != rem_tab[best]) won = rem_tab[j] < rem_tab[best];
          else won = arr_tab[j] < arr_tab[best];
          if (won) best = j;
        end
      end
      res.now = clock_now;
      if (clock_now != 16'hFFFF) clock_now++;
      if (best < 0) begin
        res.idle = 1'b1;
      end else begin
        res.job_index = 5'(best);
        rem_tab[best]--;
        if (rem_tab[best] == 0) begin
          res.job_finished = 1'b1;
          if (n_open > 0) n_open--;
          res.now = clock_now;
        end
      end
    end
    res.all_done = (n_open == 0);
    pending_results.push_back(res);
  endfunction

  function void check_schedule_result(out_item_t got);
    out_item_t want;
    bit        bad;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: now=%0d idx=%0d idle=%b fin=%b done=%b full=%b",
                 got.now, got.job_index, got.idle, got.job_finished, got.all_done,
                 got.table_full);
      return;
    end
    want = pending_results.pop_front();
    bad = (got.now !== want.now) || (got.job_index !== want.job_index) ||
          (got.idle !== want.idle) || (got.job_finished !== want.job_finished) ||
          (got.all_done !== want.all_done) || (got.table_full !== want.table_full);
    if (bad) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch: expected now=%0d idx=%0d idle=%b fin=%b done=%b full=%b,",
                  " got now=%0d idx=%0d idle=%b fin=%b done=%b full=%b"},
                 want.now, want.job_index, want.idle, want.job_finished, want.all_done,
                 want.table_full, got.now, got.job_index, got.idle, got.job_finished,
                 got.all_done, got.table_full);
    end
  endfunction
endclass

module edf_job_scheduler_top_tb;

  localparam int TB_MAX_JOBS = 32;
  localparam int N_RANDOM    = 1525;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 2 * (TB_MAX_JOBS + 3);

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_q = 1'b0;
  in_item_t  in_data_q = '0;
  logic      out_ready_q = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  schedule_tracker tracker;
  int unsigned     burst_left = 1;
  int unsigned     stuck_cycles = 0;
  logic [8:0]      rx_cycle = '0;
  int unsigned     rx_hold = 0;

  edf_job_scheduler_top #(
    .MAX_JOBS(TB_MAX_JOBS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_q),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_q),
    .out_data_o (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic in_item_t load_item(logic [15:0] arr, logic [11:0] dur, logic [15:0] dl);
    in_item_t it;
    it.func     = FUNC_LOAD;
    it.arrival  = arr;
    it.duration = dur;
    it.deadline = dl;
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it          = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    it.func     = FUNC_TICK;
    return it;
  endfunction

  function automatic logic [15:0] clip16(int unsigned v);
    return (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic in_item_t random_load();
    int unsigned base;
    logic [15:0] arr;
    logic [15:0] dl;
    logic [11:0] dur;
    base = 32'(tracker.clock_now);
    // half the jobs arrive around now, and most have deadlines close enough to compete
    if ($urandom_range(0, 1) == 0) arr = clip16(base + $urandom_range(0, 24));
    else arr = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 3) != 0) dl = clip16(base + $urandom_range(0, 300));
    else dl = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 15) == 0) dur = 12'($urandom_range(0, 4095));
    else dur = 12'($urandom_range(1, 16));
    return load_item(arr, dur, dl);
  endfunction

  task automatic send_item(input in_item_t it);
    in_data_q  <= it;
    in_valid_q <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_job_item(it);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      in_valid_q <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk_i);
    end
  endtask

  // receiver: always ready, random, long stall runs, fixed 3-of-4 pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_q) tracker.check_schedule_result(out_data_o);
    rx_cycle <= rx_cycle + 1'b1;
    case (rx_cycle[8:7])
      2'd0: out_ready_q <= 1'b1;
      2'd1: out_ready_q <= 1'($urandom_range(0, 1));
      2'd2: begin
        if (rx_hold == 0) begin
          out_ready_q <= !out_ready_q;
          rx_hold <= $urandom_range(0, 30);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
      default: out_ready_q <= (rx_cycle[1:0] != 2'd0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_q && in_ready_o) || (out_valid_o && out_ready_q)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("edf_job_scheduler_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int n;
    tracker = new(TB_MAX_JOBS);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // tick before any load
    send_item(tick_item());
    // first load sets the clock close to the top so it saturates mid-run
    send_item(load_item(16'hFD00, 12'd1, 16'hFFFF));
    send_item(tick_item());
    send_item(tick_item());
    // zero duration job counts as finished
    send_item(load_item(16'h0000, 12'd0, 16'h0000));
    send_item(tick_item());
    // long job arriving only at the saturated clock
    send_item(load_item(16'hFFFF, 12'hFFF, 16'hFFFF));
    send_item(tick_item());
    // tie rules: remaining, then arrival, then index
    send_item(load_item(16'h0000, 12'd3, 16'd500));
    send_item(load_item(16'h0000, 12'd2, 16'd500));
    send_item(load_item(16'h0005, 12'd2, 16'd500));
    send_item(load_item(16'h0000, 12'd2, 16'd500));
    // earliest deadline arriving a little later preempts
    send_item(load_item(16'hFD03, 12'd1, 16'h0000));
    repeat (10) send_item(tick_item());

    for (n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 27) == 0) send_item(random_load());
      else send_item(tick_item());
    end
    in_valid_q <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("edf_job_scheduler_top_tb: done, clean");
    end else begin
      $display("edf_job_scheduler_top_tb: done, errors");
    end
    $finish;
  end

endmodule
